// ===== sv/tpt_pkg.sv =====
`timescale 1ns / 1ps
package tpt_pkg;
	localparam int unsigned DEFAULT_DEPTH = 16;
	localparam logic [15:0] DELTA_RESET = 16'd100;

	typedef enum logic [2:0] {
		K_START  = 3'd0,
		K_CANCEL = 3'd1,
		K_POLL   = 3'd2,
		K_ACCEPT = 3'd3,
		K_CLEAR  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		E_OK      = 3'd0,
		E_BAD_ARG = 3'd1,
		E_FULL    = 3'd2,
		E_INVALID = 3'd3,
		E_STATE   = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_MATCHED   = 2'd1,
		ST_CANCELLED = 2'd2,
		ST_FAILED    = 2'd3
	} st_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] ticket_in;
		logic [15:0] mode_code;
		logic [15:0] rating;
	} req_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [31:0] ticket_out;
		logic [1:0]  match_status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FREE,
		S_OLDEST,
		S_CLAIM,
		S_MATCH,
		S_LOOK,
		S_CANCEL,
		S_PLOOK,
		S_PFIX,
		S_ACCEPT,
		S_RESULT,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic        scan_start;
		logic        scan_step;
		logic [1:0]  scan_kind;
		logic        scan_partner;
		logic        load_req;
		logic        do_claim;
		logic        do_pair;
		logic        do_cancel;
		logic        do_pfix;
		logic        do_accept;
		logic        do_clear;
		logic        set_result;
		logic [2:0]  res_err;
		logic        res_ticket;
		logic [1:0]  res_st_sel;
	} cmd_t;

	typedef struct packed {
		logic        scan_done;
		logic        found;
		logic        partner_nz;
		logic        p_found;
		logic        p_fixable;
		logic        s_matched;
		logic        mode_zero;
	} sts_t;

	localparam logic [1:0] SCAN_FREE   = 2'd0;
	localparam logic [1:0] SCAN_OLDEST = 2'd1;
	localparam logic [1:0] SCAN_MATCH  = 2'd2;
	localparam logic [1:0] SCAN_LOOK   = 2'd3;

	localparam logic [1:0] RS_FIXED = 2'd0;
	localparam logic [1:0] RS_SLOT  = 2'd1;
	localparam logic [1:0] RS_SRCH  = 2'd2;
endpackage

// ===== sv/ticket_pairing_table.sv =====
`timescale 1ns / 1ps
// channel  signals                        payload
// in       in_valid / in_ready            req_t  (kind, ticket_in, mode_code, rating)
// out      out_valid / out_ready          rsp_t  (error_code, ticket_out, match_status)
// cfg      cfg_we / cfg_wdata             max_rating_delta
// one item at a time; a start scans one slot per cycle for a free slot, else for the
// oldest retired slot, and then for a matching slot
// cancel and accept scan for the ticket and then for its partner, poll for the ticket alone
// reset empties the table at once; delta resets to 100
// a result waits in the output register; the next item is taken once it leaves
module ticket_pairing_table import tpt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	cmd_t cmd;
	sts_t sts;

	tpt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.kind(in_data.kind), .sts, .cmd
	);

	tpt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .req(in_data), .cfg_we, .cfg_wdata, .cmd, .sts, .rsp_q(out_data)
	);
endmodule

// ===== sv/tpt_datapath.sv =====
`timescale 1ns / 1ps
module tpt_datapath import tpt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  cmd_t        cmd,
	output sts_t        sts,
	output rsp_t        rsp_q
);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [TABLE_DEPTH-1:0] use_q, acc_q;
	logic [31:0] tick_q [TABLE_DEPTH];
	logic [1:0]  stat_q [TABLE_DEPTH];
	logic [15:0] mode_q [TABLE_DEPTH];
	logic [15:0] rate_q [TABLE_DEPTH];
	logic [31:0] part_q [TABLE_DEPTH];
	logic [31:0] ret_q  [TABLE_DEPTH];
	logic [31:0] nt_q, nr_q;
	logic [15:0] delta_q;
	req_t        req_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] s_q, p_q, best_q;
	logic          hit_q, best_v_q;
	logic [31:0]   key_q;
	logic [31:0]   tout_q;

	logic [IW-1:0] ci;
	logic          hit;
	logic [16:0]   diff;
	logic [31:0]   nt_inc, nr_inc, nr_nx;

	assign ci = cnt_q[IW-1:0];
	assign diff = (rate_q[ci] > req_q.rating) ? {1'b0, rate_q[ci]} - {1'b0, req_q.rating}
		: {1'b0, req_q.rating} - {1'b0, rate_q[ci]};
	assign nt_inc = (nt_q == 32'hFFFF_FFFF) ? 32'd1 : nt_q + 32'd1;
	assign nr_inc = (nr_q == 32'hFFFF_FFFF) ? 32'd1 : nr_q + 32'd1;
	assign nr_nx  = (nr_inc == 32'hFFFF_FFFF) ? 32'd1 : nr_inc + 32'd1;

	always_comb begin
		unique case (cmd.scan_kind)
			SCAN_FREE:   hit = !use_q[ci];
			SCAN_OLDEST: hit = ret_q[ci] != 32'd0 &&
				(!best_v_q || ret_q[ci] < ret_q[best_q]);
			SCAN_MATCH:  hit = ci != s_q && use_q[ci] && stat_q[ci] == ST_SEARCHING &&
				mode_q[ci] == req_q.mode_code && diff <= {1'b0, delta_q};
			default:     hit = key_q != 32'd0 && use_q[ci] && tick_q[ci] == key_q;
		endcase
	end

	assign sts.scan_done  = cnt_q == CW'(TABLE_DEPTH) ||
		(hit_q && cmd.scan_kind != SCAN_OLDEST);
	assign sts.found      = hit_q;
	assign sts.partner_nz = part_q[s_q] != 32'd0;
	assign sts.p_found    = hit_q;
	assign sts.p_fixable  = ret_q[p_q] == 32'd0 && stat_q[p_q] == ST_MATCHED;
	assign sts.s_matched  = stat_q[s_q] == ST_MATCHED;
	assign sts.mode_zero  = req_q.mode_code == 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= DELTA_RESET;
			use_q <= '0;
			nt_q <= 32'd1;
			nr_q <= 32'd1;
			cnt_q <= '0;
			hit_q <= 1'b0;
			best_v_q <= 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) ret_q[i] <= 32'd0;
		end else begin
			if (cfg_we) delta_q <= cfg_wdata;
			if (cmd.scan_start) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
				best_v_q <= 1'b0;
				if (cmd.scan_kind == SCAN_LOOK)
					key_q <= cmd.scan_partner ? part_q[s_q] : req_q.ticket_in;
			end else if (cmd.scan_step && !sts.scan_done) begin
				if (hit) begin
					hit_q <= 1'b1;
					best_v_q <= 1'b1;
					best_q <= ci;
					if (cmd.scan_kind == SCAN_MATCH ||
						(cmd.scan_kind == SCAN_LOOK && cmd.scan_partner))
						p_q <= ci;
					else if (cmd.scan_kind != SCAN_OLDEST)
						s_q <= ci;
				end
				if (!(hit && cmd.scan_kind != SCAN_OLDEST)) cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.do_claim) begin
				use_q[s_q] <= 1'b1;
				tick_q[s_q] <= nt_q;
				tout_q <= nt_q;
				stat_q[s_q] <= ST_SEARCHING;
				mode_q[s_q] <= req_q.mode_code;
				rate_q[s_q] <= req_q.rating;
				part_q[s_q] <= 32'd0;
				acc_q[s_q] <= 1'b0;
				ret_q[s_q] <= 32'd0;
				nt_q <= nt_inc;
			end
			if (cmd.do_pair) begin
				stat_q[s_q] <= ST_MATCHED;
				stat_q[p_q] <= ST_MATCHED;
				part_q[s_q] <= tick_q[p_q];
				part_q[p_q] <= tout_q;
			end
			if (cmd.do_pfix) begin
				stat_q[p_q] <= ST_SEARCHING;
				part_q[p_q] <= 32'd0;
				acc_q[p_q] <= 1'b0;
			end
			if (cmd.do_cancel) begin
				stat_q[s_q] <= ST_CANCELLED;
				part_q[s_q] <= 32'd0;
				if (ret_q[s_q] == 32'd0) begin
					ret_q[s_q] <= nr_q;
					nr_q <= nr_inc;
				end
			end
			if (cmd.do_accept) begin
				acc_q[s_q] <= 1'b1;
				if (!sts.partner_nz) begin
					if (ret_q[s_q] == 32'd0) begin
						ret_q[s_q] <= nr_q;
						nr_q <= nr_inc;
					end
				end else if (hit_q && (acc_q[p_q] || p_q == s_q)) begin
					if (ret_q[s_q] == 32'd0 && ret_q[p_q] == 32'd0 && p_q != s_q) begin
						ret_q[s_q] <= nr_q;
						ret_q[p_q] <= nr_inc;
						nr_q <= nr_nx;
					end else if (ret_q[s_q] == 32'd0) begin
						ret_q[s_q] <= nr_q;
						nr_q <= nr_inc;
					end else if (ret_q[p_q] == 32'd0) begin
						ret_q[p_q] <= nr_q;
						nr_q <= nr_inc;
					end
				end
			end
			if (cmd.do_clear) begin
				use_q <= '0;
				nt_q <= 32'd1;
				nr_q <= 32'd1;
				for (int i = 0; i < TABLE_DEPTH; i++) ret_q[i] <= 32'd0;
			end
			if (cmd.scan_kind == SCAN_OLDEST && cmd.do_claim == 1'b0 && sts.scan_done &&
				cmd.scan_step)
				s_q <= best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.set_result) begin
			rsp_q.error_code <= cmd.res_err;
			rsp_q.ticket_out <= cmd.res_ticket ? tout_q : 32'd0;
			unique case (cmd.res_st_sel)
				RS_SLOT: rsp_q.match_status <= stat_q[s_q];
				RS_SRCH: rsp_q.match_status <= ST_SEARCHING;
				default: rsp_q.match_status <= ST_FAILED;
			endcase
		end
	end
endmodule

// ===== sv/tpt_ctrl.sv =====
`timescale 1ns / 1ps
module tpt_ctrl import tpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [2:0] kind,
	input  sts_t sts,
	output cmd_t cmd
);
	fsm_t state_q, state_d;
	logic [2:0] kind_q;
	logic       ov_q, ov_d;

	assign in_ready  = state_q == S_IDLE && !ov_q;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			kind_q <= '0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			if (in_valid && in_ready) kind_q <= kind;
		end
	end

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		cmd.scan_kind = SCAN_LOOK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_req = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (kind_q)
					K_START: begin
						if (sts.mode_zero) begin
							cmd.set_result = 1'b1;
							cmd.res_err = E_BAD_ARG;
							cmd.res_st_sel = RS_FIXED;
							state_d = S_OUT;
						end else begin
							cmd.scan_kind = SCAN_FREE;
							cmd.scan_start = 1'b1;
							state_d = S_FREE;
						end
					end
					K_CANCEL, K_POLL, K_ACCEPT: begin
						cmd.scan_kind = SCAN_LOOK;
						cmd.scan_start = 1'b1;
						cmd.load_req = 1'b0;
						state_d = S_LOOK;
					end
					K_CLEAR: begin
						cmd.do_clear = 1'b1;
						cmd.set_result = 1'b1;
						cmd.res_err = E_OK;
						cmd.res_st_sel = RS_SRCH;
						state_d = S_OUT;
					end
					default: begin
						cmd.set_result = 1'b1;
						cmd.res_err = E_BAD_ARG;
						cmd.res_st_sel = RS_FIXED;
						state_d = S_OUT;
					end
				endcase
			end
			default: ;
		endcase
		unique case (state_q)
			S_FREE: begin
				cmd.scan_kind = SCAN_FREE;
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.found) begin
						state_d = S_CLAIM;
					end else begin
						cmd.scan_step = 1'b0;
						cmd.scan_kind = SCAN_OLDEST;
						cmd.scan_start = 1'b1;
						state_d = S_OLDEST;
					end
				end
			end
			S_OLDEST: begin
				cmd.scan_kind = SCAN_OLDEST;
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (sts.found) begin
						state_d = S_CLAIM;
					end else begin
						cmd.set_result = 1'b1;
						cmd.res_err = E_FULL;
						cmd.res_st_sel = RS_FIXED;
						state_d = S_OUT;
					end
				end
			end
			S_CLAIM: begin
				cmd.scan_kind = SCAN_MATCH;
				cmd.do_claim = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = S_MATCH;
			end
			S_MATCH: begin
				cmd.scan_kind = SCAN_MATCH;
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					cmd.scan_step = 1'b0;
					cmd.do_pair = sts.found;
					state_d = S_RESULT;
				end
			end
			S_LOOK: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					if (!sts.found) begin
						cmd.set_result = 1'b1;
						cmd.res_err = (kind_q == K_POLL) ? E_OK : E_INVALID;
						cmd.res_st_sel = RS_FIXED;
						state_d = S_OUT;
					end else if (kind_q == K_POLL) begin
						state_d = S_RESULT;
					end else if (kind_q == K_ACCEPT && !sts.s_matched) begin
						cmd.set_result = 1'b1;
						cmd.res_err = E_STATE;
						cmd.res_st_sel = RS_SLOT;
						state_d = S_OUT;
					end else begin
						state_d = S_CANCEL;
					end
				end
			end
			S_CANCEL: begin
				if (sts.partner_nz) begin
					cmd.scan_start = 1'b1;
					cmd.scan_partner = 1'b1;
					state_d = S_PLOOK;
				end else if (kind_q == K_CANCEL) begin
					cmd.do_cancel = 1'b1;
					state_d = S_RESULT;
				end else begin
					cmd.do_accept = 1'b1;
					state_d = S_RESULT;
				end
			end
			S_PLOOK: begin
				cmd.scan_step = 1'b1;
				cmd.scan_partner = 1'b1;
				if (sts.scan_done) state_d = (kind_q == K_CANCEL) ? S_PFIX : S_ACCEPT;
			end
			S_PFIX: begin
				cmd.do_pfix = sts.p_found && sts.p_fixable;
				state_d = S_ACCEPT;
			end
			S_ACCEPT: begin
				if (kind_q == K_CANCEL) cmd.do_cancel = 1'b1;
				else cmd.do_accept = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				cmd.set_result = 1'b1;
				cmd.res_err = E_OK;
				cmd.res_ticket = kind_q == K_START;
				cmd.res_st_sel = RS_SLOT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!ov_q) begin
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import tpt_pkg::*;

	localparam int DEPTH = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	ticket_pairing_table #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// table mirror
	logic        t_used [DEPTH];
	logic [31:0] t_ticket [DEPTH];
	st_t         t_status [DEPTH];
	logic [15:0] t_mode [DEPTH];
	logic [15:0] t_rating [DEPTH];
	logic [31:0] t_partner [DEPTH];
	logic        t_accepted [DEPTH];
	logic [31:0] t_retired [DEPTH];
	logic [31:0] ticket_ctr, retire_ctr;
	logic [15:0] rating_delta;

	rsp_t expected_rsp [$];
	int mismatches = 0;
	bit rx_stall = 1'b1;

	function automatic logic [31:0] bump(logic [31:0] v);
		v = v + 1;
		return v == 0 ? 32'd1 : v;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < DEPTH; i++) begin
			t_used[i] = 0; t_ticket[i] = 0; t_status[i] = ST_SEARCHING;
			t_mode[i] = 0; t_rating[i] = 0; t_partner[i] = 0;
			t_accepted[i] = 0; t_retired[i] = 0;
		end
		ticket_ctr = 1;
		retire_ctr = 1;
	endfunction

	function automatic int find_ticket(logic [31:0] t);
		if (t == 0) return DEPTH;
		for (int i = 0; i < DEPTH; i++)
			if (t_used[i] && t_ticket[i] == t) return i;
		return DEPTH;
	endfunction

	function automatic void retire_slot(int i);
		if (t_retired[i] != 0) return;
		t_retired[i] = retire_ctr;
		retire_ctr = bump(retire_ctr);
	endfunction

	function automatic int claim_slot();
		int best;
		best = DEPTH;
		for (int i = 0; i < DEPTH; i++)
			if (!t_used[i]) return i;
		for (int i = 0; i < DEPTH; i++)
			if (t_retired[i] != 0 && (best == DEPTH || t_retired[i] < t_retired[best]))
				best = i;
		return best;
	endfunction

	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int s, p;
		logic [15:0] d;
		o.error_code = E_OK;
		o.ticket_out = 0;
		o.match_status = ST_FAILED;
		case (r.kind)
			K_START: begin
				if (r.mode_code == 0) begin
					o.error_code = E_BAD_ARG;
				end else begin
					s = claim_slot();
					if (s >= DEPTH) begin
						o.error_code = E_FULL;
					end else begin
						o.ticket_out = ticket_ctr;
						ticket_ctr = bump(ticket_ctr);
						t_used[s] = 1; t_ticket[s] = o.ticket_out;
						t_status[s] = ST_SEARCHING; t_mode[s] = r.mode_code;
						t_rating[s] = r.rating; t_partner[s] = 0;
						t_accepted[s] = 0; t_retired[s] = 0;
						for (int i = 0; i < DEPTH; i++) begin
							if (i == s || !t_used[i] || t_status[i] != ST_SEARCHING) continue;
							if (t_mode[i] != r.mode_code) continue;
							d = t_rating[i] > r.rating ? t_rating[i] - r.rating
								: r.rating - t_rating[i];
							if (d <= rating_delta) begin
								t_status[s] = ST_MATCHED;
								t_status[i] = ST_MATCHED;
								t_partner[s] = t_ticket[i];
								t_partner[i] = o.ticket_out;
								break;
							end
						end
						o.match_status = t_status[s];
					end
				end
			end
			K_CANCEL: begin
				s = find_ticket(r.ticket_in);
				if (s >= DEPTH) begin
					o.error_code = E_INVALID;
				end else begin
					if (t_partner[s] != 0) begin
						p = find_ticket(t_partner[s]);
						if (p < DEPTH && t_retired[p] == 0 && t_status[p] == ST_MATCHED) begin
							t_status[p] = ST_SEARCHING;
							t_partner[p] = 0;
							t_accepted[p] = 0;
						end
					end
					t_status[s] = ST_CANCELLED;
					t_partner[s] = 0;
					retire_slot(s);
					o.match_status = t_status[s];
				end
			end
			K_POLL: begin
				s = find_ticket(r.ticket_in);
				if (s < DEPTH) o.match_status = t_status[s];
			end
			K_ACCEPT: begin
				s = find_ticket(r.ticket_in);
				if (s >= DEPTH) begin
					o.error_code = E_INVALID;
				end else if (t_status[s] != ST_MATCHED) begin
					o.error_code = E_STATE;
					o.match_status = t_status[s];
				end else begin
					t_accepted[s] = 1;
					if (t_partner[s] != 0) begin
						p = find_ticket(t_partner[s]);
						if (p < DEPTH && t_accepted[p]) begin
							retire_slot(s);
							retire_slot(p);
						end
					end else begin
						retire_slot(s);
					end
					o.match_status = t_status[s];
				end
			end
			K_CLEAR: begin
				wipe_table();
				o.match_status = ST_SEARCHING;
			end
			default: o.error_code = E_BAD_ARG;
		endcase
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// valid stays up into the next item when there is no gap
	task automatic send_item(req_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		expected_rsp.push_back(serve_request(r));
		in_data <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_stall)
			out_ready <= ($urandom_range(0, 99) < 70);
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (e !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", e, out_data);
				end
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (3 * DEPTH + 20) @(posedge clk);
	endtask

	task automatic set_delta(logic [15:0] v);
		drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		rating_delta = v;
	endtask

	function automatic req_t make_req(kind_t k, logic [31:0] t, logic [15:0] m,
		logic [15:0] rt);
		req_t r;
		r.kind = k; r.ticket_in = t; r.mode_code = m; r.rating = rt;
		return r;
	endfunction

	function automatic logic [31:0] live_ticket();
		int lo;
		lo = (ticket_ctr > 24) ? ticket_ctr - 24 : 1;
		if (ticket_ctr <= 1) return $urandom_range(0, 3);
		return $urandom_range(lo, ticket_ctr - 1);
	endfunction

	task automatic test_directed();
		send_item(make_req(K_START, 0, 0, 5));
		send_item(make_req(K_START, 0, 16'hFFFF, 16'hFFFF));
		send_item(make_req(K_START, 0, 16'hFFFF, 16'hFF9B));
		send_item(make_req(K_START, 0, 16'hFFFF, 16'hFF9A));
		send_item(make_req(K_POLL, 1, 0, 0));
		send_item(make_req(K_POLL, 0, 0, 0));
		send_item(make_req(K_POLL, 32'hFFFFFFFF, 0, 0));
		send_item(make_req(K_ACCEPT, 3, 0, 0));
		send_item(make_req(K_ACCEPT, 1, 0, 0));
		send_item(make_req(K_ACCEPT, 2, 0, 0));
		send_item(make_req(K_ACCEPT, 1, 0, 0));
		send_item(make_req(K_CANCEL, 1, 0, 0));
		send_item(make_req(K_CANCEL, 3, 0, 0));
		send_item(make_req(K_CANCEL, 3, 0, 0));
		send_item(make_req(K_CANCEL, 0, 0, 0));
		send_item(make_req(K_ACCEPT, 99, 0, 0));
		send_item(req_t'({3'd5, 32'h1, 16'h1, 16'h1}));
		send_item(req_t'({3'd7, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF}));
		for (int i = 0; i < DEPTH + 1; i++)
			send_item(make_req(K_START, 0, 16'(16'h8000 + i), 16'h0));
		send_item(make_req(K_CLEAR, 0, 0, 0));
	endtask

	task automatic test_random(int n);
		req_t r;
		int c;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(0, 99);
			r = make_req(K_START, 0, 16'($urandom_range(1, 3)), 16'($urandom_range(0, 400)));
			if (c < 40) begin
				if ($urandom_range(0, 19) == 0) r.mode_code = 16'($urandom);
				if ($urandom_range(0, 9) == 0) r.rating = 16'($urandom);
				if ($urandom_range(0, 29) == 0) r.mode_code = 0;
			end else if (c < 55) begin
				r = make_req(K_CANCEL, live_ticket(), 16'($urandom), 16'($urandom));
			end else if (c < 75) begin
				r = make_req(K_ACCEPT, live_ticket(), 16'($urandom), 16'($urandom));
			end else if (c < 90) begin
				r = make_req(K_POLL, live_ticket(), 16'($urandom), 16'($urandom));
			end else if (c < 97) begin
				r.kind = K_POLL;
				r.ticket_in = $urandom;
			end else if (c < 99) begin
				r.kind = 3'($urandom_range(5, 7));
				r.ticket_in = $urandom;
			end else begin
				r.kind = K_CLEAR;
			end
			send_item(r);
		end
	endtask

	initial begin
		rating_delta = DELTA_RESET;
		wipe_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		set_delta(16'd0);
		test_random(300);
		set_delta(16'hFFFF);
		test_random(300);
		rx_stall = 1'b0;
		set_delta(16'd30);
		test_random(300);
		rx_stall = 1'b1;
		set_delta(16'd100);
		test_random(330);
		drain();
		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/tpt_pkg.sv
sv/tpt_datapath.sv
sv/tpt_ctrl.sv
sv/ticket_pairing_table.sv
bench/testbench.sv
